[rtl/core/ffaa_pkg.sv]
// ----------------------------------------------------------------------------
// ffaa_pkg: shared types and constants of the first-fit arena allocator
// Item layouts, operation and status codes, default arena sizes and the
// per-granule mark pair carried along the granule ring.
// ----------------------------------------------------------------------------
package ffaa_pkg;

   localparam int ARENA_BYTES_DEF   = 1024;
   localparam int GRANULE_BYTES_DEF = 16;

   localparam int REQ_BYTES_W = 10;
   localparam int OFFSET_W    = 10;
   localparam int STATUS_W    = 2;

   localparam logic FUNC_ALLOC   = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOSPACE  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

   typedef struct packed {
      logic                   func;
      logic [REQ_BYTES_W-1:0] request_bytes;
      logic [OFFSET_W-1:0]    release_offset;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [OFFSET_W-1:0] data_offset;
   } rsp_type;

   // Marks of one granule: block header, and allocated (meaningful at a header).
   typedef struct packed {
      logic start;
      logic used;
   } gran_type;

endpackage

[rtl/core/ffaa_cell.sv]
// ----------------------------------------------------------------------------
// ffaa_cell: one granule position of the granule ring
// Holds the header and allocated marks of one granule and takes its
// neighbor's marks whenever the ring rotates.
// ----------------------------------------------------------------------------
module ffaa_cell
   import ffaa_pkg::*;
#(
   parameter bit START_AT_RESET = 1'b0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     shift_en,
   input  gran_type shift_in,
   output gran_type value
);

   gran_type value_ff;
   gran_type value_in;

   always_comb begin
      value_in = value_ff;
      if (shift_en) begin
         value_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff.start <= START_AT_RESET;
         value_ff.used  <= 1'b0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

[rtl/core/ffaa_ctrl.sv]
// ----------------------------------------------------------------------------
// ffaa_ctrl: scan controller of the first-fit arena allocator
// Watches the granule at the head of the ring, runs the first-fit search or
// the release and merge on it, and feeds the updated marks to the tail.
// ----------------------------------------------------------------------------
module ffaa_ctrl
   import ffaa_pkg::*;
#(
   parameter int ARENA_BYTES   = ARENA_BYTES_DEF,
   parameter int GRANULE_BYTES = GRANULE_BYTES_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data,
   input  gran_type head,
   output gran_type tail,
   output logic     shift_en
);

   localparam int NGRAN = ARENA_BYTES / GRANULE_BYTES;
   localparam int GW    = (NGRAN > 1) ? $clog2(NGRAN) : 1;
   localparam int AW    = $clog2(ARENA_BYTES + 1);
   localparam int CW    = (AW > OFFSET_W) ? AW : OFFSET_W;

   localparam logic [GW-1:0] LAST_GRAN = GW'(NGRAN - 1);
   localparam logic [AW-1:0] GRAN_STEP = AW'(GRANULE_BYTES);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   // Control state.
   logic [1:0]             state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   pend_valid_ff, pend_valid_in;

   // Item and scan payload.
   logic [GW-1:0]          g_ff, g_in;
   logic [AW-1:0]          acc_ff, acc_in;
   logic                   func_ff, func_in;
   logic [REQ_BYTES_W-1:0] req_bytes_ff, req_bytes_in;
   logic [OFFSET_W-1:0]    rel_off_ff, rel_off_in;
   logic [GW-1:0]          blk_h_ff, blk_h_in;
   logic                   blk_used_ff, blk_used_in;
   logic [AW-1:0]          blk_bytes_ff, blk_bytes_in;
   logic [AW-1:0]          blk_data_ff, blk_data_in;
   logic [GW-1:0]          blk_s_ff, blk_s_in;
   logic                   blk_s_set_ff, blk_s_set_in;
   logic                   found_ff, found_in;
   logic [GW-1:0]          hit_h_ff, hit_h_in;
   logic [AW-1:0]          hit_data_ff, hit_data_in;
   logic                   hit_split_ff, hit_split_in;
   logic [GW-1:0]          hit_s_ff, hit_s_in;
   logic                   prev_free_ff, prev_free_in;
   logic [GW-1:0]          pend_h_ff, pend_h_in;
   logic                   pend_split_ff, pend_split_in;
   logic [GW-1:0]          pend_s_ff, pend_s_in;
   rsp_type                rsp_ff, rsp_in;

   gran_type view;
   gran_type wb;
   logic     match;
   logic     blk_fit;

   // The last grant is held as a pending edit and laid over the ring marks as
   // each granule passes the head, so a grant never needs a second pass.
   always_comb begin
      view = head;
      if (pend_valid_ff && g_ff == pend_h_ff) begin
         view.used = 1'b1;
      end
      if (pend_valid_ff && pend_split_ff && g_ff == pend_s_ff) begin
         view.start = 1'b1;
         view.used  = 1'b0;
      end
   end

   // A data area of n granules fits a request of b bytes when n*G >= b.
   assign blk_fit = !blk_used_ff && (CW'(blk_bytes_ff) >= CW'(req_bytes_ff));

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      pend_valid_in = pend_valid_ff;
      g_in          = g_ff;
      acc_in        = acc_ff;
      func_in       = func_ff;
      req_bytes_in  = req_bytes_ff;
      rel_off_in    = rel_off_ff;
      blk_h_in      = blk_h_ff;
      blk_used_in   = blk_used_ff;
      blk_bytes_in  = blk_bytes_ff;
      blk_data_in   = blk_data_ff;
      blk_s_in      = blk_s_ff;
      blk_s_set_in  = blk_s_set_ff;
      found_in      = found_ff;
      hit_h_in      = hit_h_ff;
      hit_data_in   = hit_data_ff;
      hit_split_in  = hit_split_ff;
      hit_s_in      = hit_s_ff;
      prev_free_in  = prev_free_ff;
      pend_h_in     = pend_h_ff;
      pend_split_in = pend_split_ff;
      pend_s_in     = pend_s_ff;
      rsp_in        = rsp_ff;
      shift_en      = 1'b0;
      match         = 1'b0;
      wb            = view;
      tail          = view;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in      = req_data.func;
               req_bytes_in = req_data.request_bytes;
               rel_off_in   = req_data.release_offset;
               g_in         = '0;
               acc_in       = GRAN_STEP;
               found_in     = 1'b0;
               prev_free_in = 1'b0;
               blk_used_in  = 1'b1;
               blk_bytes_in = '0;
               blk_s_set_in = 1'b0;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            shift_en = 1'b1;
            g_in     = g_ff + GW'(1);
            acc_in   = acc_ff + GRAN_STEP;
            if (func_ff == FUNC_ALLOC) begin
               // A header closes the previous block; judge it before opening the next.
               if (view.start && g_ff != '0 && !found_ff && blk_fit) begin
                  found_in     = 1'b1;
                  hit_h_in     = blk_h_ff;
                  hit_data_in  = blk_data_ff;
                  hit_split_in = blk_s_set_ff && (blk_h_ff == '0);
                  hit_s_in     = blk_s_ff;
               end
               if (view.start) begin
                  blk_h_in     = g_ff;
                  blk_used_in  = view.used;
                  blk_bytes_in = '0;
                  blk_data_in  = acc_ff;
                  blk_s_set_in = 1'b0;
               end else begin
                  // The first granule past the requested bytes is where a split
                  // remainder would put its header.
                  if (!blk_s_set_ff && CW'(blk_bytes_ff) >= CW'(req_bytes_ff)) begin
                     blk_s_in     = g_ff;
                     blk_s_set_in = 1'b1;
                  end
                  blk_bytes_in = blk_bytes_ff + GRAN_STEP;
               end
               tail = view;
            end else begin
               match = view.start && (CW'(acc_ff) == CW'(rel_off_ff));
               wb    = view;
               if (match) begin
                  wb.used = 1'b0;
               end
               if (wb.start) begin
                  if (!wb.used && prev_free_ff && (found_ff || match)) begin
                     wb = '0;
                  end else begin
                     prev_free_in = !wb.used;
                  end
               end
               found_in = found_ff || match;
               tail     = wb;
            end
            if (g_ff == LAST_GRAN) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
               pend_valid_in = 1'b0;
               pend_split_in = 1'b0;
               rsp_in.data_offset = '0;
               if (func_ff == FUNC_ALLOC) begin
                  if (found_ff) begin
                     pend_valid_in      = 1'b1;
                     pend_h_in          = hit_h_ff;
                     pend_split_in      = hit_split_ff;
                     pend_s_in          = hit_s_ff;
                     rsp_in.status      = ST_DONE;
                     rsp_in.data_offset = OFFSET_W'(hit_data_ff);
                  end else if (blk_fit) begin
                     // The last block runs to the end of the arena and may split.
                     pend_valid_in      = 1'b1;
                     pend_h_in          = blk_h_ff;
                     pend_split_in      = blk_s_set_ff;
                     pend_s_in          = blk_s_ff;
                     rsp_in.status      = ST_DONE;
                     rsp_in.data_offset = OFFSET_W'(blk_data_ff);
                  end else begin
                     rsp_in.status = ST_NOSPACE;
                  end
               end else begin
                  rsp_in.status = found_ff ? ST_DONE : ST_NOTFOUND;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      g_ff          <= g_in;
      acc_ff        <= acc_in;
      func_ff       <= func_in;
      req_bytes_ff  <= req_bytes_in;
      rel_off_ff    <= rel_off_in;
      blk_h_ff      <= blk_h_in;
      blk_used_ff   <= blk_used_in;
      blk_bytes_ff  <= blk_bytes_in;
      blk_data_ff   <= blk_data_in;
      blk_s_ff      <= blk_s_in;
      blk_s_set_ff  <= blk_s_set_in;
      found_ff      <= found_in;
      hit_h_ff      <= hit_h_in;
      hit_data_ff   <= hit_data_in;
      hit_split_ff  <= hit_split_in;
      hit_s_ff      <= hit_s_in;
      prev_free_ff  <= prev_free_in;
      pend_h_ff     <= pend_h_in;
      pend_split_ff <= pend_split_in;
      pend_s_ff     <= pend_s_in;
      rsp_ff        <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/core/first_fit_arena_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_arena_allocator: first-fit allocator with coalescing
// Arena of ARENA_BYTES in granules of GRANULE_BYTES, one header granule per
// block, kept as a rotating ring of granule cells scanned by one controller.
// ----------------------------------------------------------------------------
// Usage:
// An item on the req_ channel is either an allocate (func = 0) with a byte
// count, or a release (func = 1) naming a block by its data offset. Every
// item gives exactly one item on the rsp_ channel: a status (done, no space,
// or offset not found) and, for a granted allocate, the data offset.
// Each granule's header and allocated marks live in a cell of a ring. While
// an item is worked on, the ring rotates one position per cycle past the
// controller, which reads the granule at the head and writes its updated
// marks back at the tail; after ARENA_BYTES/GRANULE_BYTES rotations the ring
// is aligned again. An item is accepted, then scanned granule by granule; at
// the end the last block is closed and the result is posted.
// A grant is kept as a pending edit and merged into the marks during the next
// item's pass, so every item needs a single pass. The next item is accepted
// as soon as the result is posted, even if it has not been taken yet; if the
// receiver stalls, the next item's scan finishes and then waits for the slot.
// Reset makes the whole arena one free block and drops any pending edit.
// ----------------------------------------------------------------------------
module first_fit_arena_allocator
   import ffaa_pkg::*;
#(
   parameter int ARENA_BYTES   = ARENA_BYTES_DEF,
   parameter int GRANULE_BYTES = GRANULE_BYTES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int NGRAN = ARENA_BYTES / GRANULE_BYTES;

   gran_type ring [NGRAN];
   gran_type tail;
   logic     shift_en;

   // The ring moves toward cell zero; the controller feeds the last cell.
   for (genvar i = 0; i < NGRAN; i++) begin : g_ring
      gran_type shift_src;
      if (i == NGRAN - 1) begin : g_last
         assign shift_src = tail;
      end else begin : g_mid
         assign shift_src = ring[i+1];
      end
      ffaa_cell #(
         .START_AT_RESET(i == 0)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .shift_en(shift_en),
         .shift_in(shift_src),
         .value   (ring[i])
      );
   end

   ffaa_ctrl #(
      .ARENA_BYTES  (ARENA_BYTES),
      .GRANULE_BYTES(GRANULE_BYTES)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .head     (ring[0]),
      .tail     (tail),
      .shift_en (shift_en)
   );

endmodule

[rtl/core/ffaa_chk.sv]
// ----------------------------------------------------------------------------
// ffaa_chk: port checker of the first-fit arena allocator
// Watches the top-level ports and flags handshake and result slips.
// ----------------------------------------------------------------------------
module ffaa_chk
   import ffaa_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A stalled result item holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // Only defined status codes leave the block.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == ST_DONE || rsp_data.status == ST_NOSPACE ||
                     rsp_data.status == ST_NOTFOUND))
      else $error("undefined status code");

   // A refusal carries no offset.
   a_refusal_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_DONE |-> rsp_data.data_offset == '0)
      else $error("refused item carries an offset");

   // One item at a time: the block is busy right after taking an item.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while another is in work");

   // Nothing is offered right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

endmodule

bind first_fit_arena_allocator ffaa_chk u_ffaa_chk (.*);
